@@ sv/assert_macros.svh @@
// assertion macros shared by the tea block decrypt rtl
// no dependencies; included by the files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define TBD_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("tea block decrypt: assertion failed");

// condition in one cycle implies a result in the next cycle
`define TBD_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("tea block decrypt: assertion failed");

`endif

@@ sv/tbd_pkg.sv @@
// package for the tea block decrypt: types, key constants, round functions
// no dependencies
package tbd_pkg;

   localparam int unsigned DEFAULT_ROUNDS = 32;
   localparam int unsigned WORD_WIDTH = 32;
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned CSR_INDEX_WIDTH = 2;

   localparam logic [WORD_WIDTH-1:0] TEA_DELTA = 32'h9e37_79b9;

   localparam logic [WORD_WIDTH-1:0] KEY_0_RESET = 32'h2016_0903;
   localparam logic [WORD_WIDTH-1:0] KEY_1_RESET = 32'hfafb_fcfd;
   localparam logic [WORD_WIDTH-1:0] KEY_2_RESET = 32'h2016_0708;
   localparam logic [WORD_WIDTH-1:0] KEY_3_RESET = 32'heaeb_eced;

   // register indexes of the config port
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_WORD_0 = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_WORD_1 = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_WORD_2 = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_WORD_3 = 2'd3;

   typedef logic [WORD_WIDTH-1:0] word_type;

   typedef struct packed {
      word_type hi;
      word_type lo;
   } block_type;

   typedef struct packed {
      word_type k0;
      word_type k1;
      word_type k2;
      word_type k3;
   } key_type;

   // head of the input queue as seen by the round pipeline
   typedef struct packed {
      logic      valid;
      block_type data;
   } head_type;

   // running sum of one round, worked out at elaboration
   function automatic word_type round_sum(int unsigned rounds, int unsigned round_idx);
      logic [63:0] prod;
      prod = 64'(rounds - round_idx) * 64'(TEA_DELTA);
      return prod[WORD_WIDTH-1:0];
   endfunction

   function automatic word_type mix_half(word_type w, word_type sum, word_type kl,
                                         word_type kr);
      return ((w << 4) + kl) ^ (w + sum) ^ ((w >> 5) + kr);
   endfunction

endpackage

@@ sv/tea_block_decrypt.sv @@
// top level of the tea block decrypt: key registers, input queue, round pipeline
// depends on tbd_pkg, tbd_queue and tbd_rounds
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  req_cipher_high, req_cipher_low
//   rsp      out        rsp_valid / rsp_stall  rsp_plain_high, rsp_plain_low
//   csr      in         csr_valid / csr_ready  csr_index, csr_data
//
// one item enters per cycle while req_stall is low; each item passes through the input
// queue and then the half-round pipe
// synchronous active-high reset empties queue and pipe and loads the fixed key
// req_stall is raised only when the two-entry queue is full
// a stalled result freezes the whole pipe; the queue keeps taking items until full
module tea_block_decrypt #(
   parameter int unsigned ROUNDS = tbd_pkg::DEFAULT_ROUNDS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [31:0]                           req_cipher_high,
   input  logic [31:0]                           req_cipher_low,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [31:0]                           rsp_plain_high,
   output logic [31:0]                           rsp_plain_low,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [tbd_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [31:0]                           csr_data
);

   tbd_pkg::key_type key_ff;
   tbd_pkg::block_type req_block;
   tbd_pkg::block_type rsp_block;
   tbd_pkg::head_type head;
   logic push;
   logic pop;
   logic queue_full;

   // key writes are always taken at once
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff.k0 <= tbd_pkg::KEY_0_RESET;
         key_ff.k1 <= tbd_pkg::KEY_1_RESET;
         key_ff.k2 <= tbd_pkg::KEY_2_RESET;
         key_ff.k3 <= tbd_pkg::KEY_3_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            tbd_pkg::CSR_KEY_WORD_0: key_ff.k0 <= csr_data;
            tbd_pkg::CSR_KEY_WORD_1: key_ff.k1 <= csr_data;
            tbd_pkg::CSR_KEY_WORD_2: key_ff.k2 <= csr_data;
            tbd_pkg::CSR_KEY_WORD_3: key_ff.k3 <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // front: accept items into the queue
   assign req_stall = queue_full;
   assign push = req_valid && !req_stall;
   assign req_block.hi = req_cipher_high;
   assign req_block.lo = req_cipher_low;

   tbd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (req_block),
      .full      (queue_full),
      .pop       (pop),
      .head      (head)
   );

   // back: half-round pipeline, its last stage is the output register
   tbd_rounds #(
      .ROUNDS (ROUNDS)
   ) u_rounds (
      .clock     (clock),
      .reset     (reset),
      .key       (key_ff),
      .head      (head),
      .pop       (pop),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_block)
   );

   assign rsp_plain_high = rsp_block.hi;
   assign rsp_plain_low = rsp_block.lo;

endmodule

@@ sv/tbd_queue.sv @@
// input queue of the tea block decrypt: takes items and holds them for the rounds
// depends on tbd_pkg and assert_macros.svh
`include "assert_macros.svh"

module tbd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  tbd_pkg::block_type push_data,
   output logic               full,
   input  logic               pop,
   output tbd_pkg::head_type  head
);

   localparam int unsigned DEPTH = tbd_pkg::QUEUE_DEPTH;
   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   tbd_pkg::block_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full = (count_ff == FULL_CNT);
   assign head.valid = (count_ff != '0);
   assign head.data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `TBD_ASSERT(a_count_bounded, clock, reset, count_ff <= FULL_CNT)
   `TBD_ASSERT(a_no_pop_empty, clock, reset, !pop || count_ff != '0)
   `TBD_ASSERT(a_no_push_full, clock, reset, !push || count_ff != FULL_CNT)

endmodule

@@ sv/tbd_rounds.sv @@
// round pipeline of the tea block decrypt: one half round per stage
// depends on tbd_pkg and assert_macros.svh
`include "assert_macros.svh"

module tbd_rounds #(
   parameter int unsigned ROUNDS = tbd_pkg::DEFAULT_ROUNDS
) (
   input  logic               clock,
   input  logic               reset,
   input  tbd_pkg::key_type   key,
   input  tbd_pkg::head_type  head,
   output logic               pop,
   output logic               out_valid,
   input  logic               out_stall,
   output tbd_pkg::block_type out_data
);

   localparam int unsigned STAGES = 2 * ROUNDS;

   logic [STAGES-1:0] valid_ff, valid_in;
   tbd_pkg::block_type data_ff [STAGES];
   tbd_pkg::block_type data_in [STAGES];
   logic advance;

   // whole pipe moves unless the finished item at the end is held
   assign advance = !valid_ff[STAGES-1] || !out_stall;
   assign pop = advance && head.valid;
   assign out_valid = valid_ff[STAGES-1];
   assign out_data = data_ff[STAGES-1];

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      localparam int unsigned RND = s / 2;
      localparam tbd_pkg::word_type SUM = tbd_pkg::round_sum(ROUNDS, RND);
      tbd_pkg::block_type prev;

      if (s == 0) begin : g_first
         assign prev = head.data;
         assign valid_in[s] = head.valid;
      end else begin : g_next
         assign prev = data_ff[s-1];
         assign valid_in[s] = valid_ff[s-1];
      end

      if ((s % 2) == 0) begin : g_low
         // second word first, keyed by words 2 and 3
         assign data_in[s].hi = prev.hi;
         assign data_in[s].lo = prev.lo - tbd_pkg::mix_half(prev.hi, SUM, key.k2, key.k3);
      end else begin : g_high
         assign data_in[s].lo = prev.lo;
         assign data_in[s].hi = prev.hi - tbd_pkg::mix_half(prev.lo, SUM, key.k0, key.k1);
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            data_ff[s] <= data_in[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   `TBD_ASSERT_NEXT(a_hold_when_stalled, clock, reset,
      valid_ff[STAGES-1] && out_stall, $stable(valid_ff))
   `TBD_ASSERT_NEXT(a_no_result_from_bubble, clock, reset,
      !valid_ff[STAGES-1] && !valid_ff[STAGES-2], !valid_ff[STAGES-1])

endmodule

@@ bench/tea_block_decrypt_tb.sv @@
// self-checking bench for tea_block_decrypt: directed corner blocks, key changes, random traffic
// and long output stalls, each plaintext predicted by a decipher routine kept inside the bench
// depends on tbd_pkg and the tea_block_decrypt top level
module tea_block_decrypt_tb;
   import tbd_pkg::*;

   localparam int unsigned ROUNDS = DEFAULT_ROUNDS;
   localparam int unsigned CLOCK_PERIOD = 8;
   // half-round pipe plus the input queue
   localparam int unsigned PIPE_LATENCY = 2 * ROUNDS + 1;
   // long enough to fill the pipe and the queue behind it
   localparam int unsigned HOLD_CYCLES = 240;
   localparam int unsigned DRAIN_LIMIT = 50000;
   localparam int unsigned TIMEOUT_CYCLES = 400000;
   localparam word_type ALL_ONES = '1;

   // corner ciphertexts: extremes, alternating bits, single high/low bits and
   // the all-zero-key encryption of an all-zero block
   localparam logic [63:0] CORNER_BLOCKS [9] = '{
      64'h00000000_00000000,
      64'hffffffff_ffffffff,
      64'h00000000_ffffffff,
      64'hffffffff_00000000,
      64'haaaaaaaa_55555555,
      64'h55555555_aaaaaaaa,
      64'h80000000_00000001,
      64'h00000001_80000000,
      64'h41ea3a0a_94baa940
   };

   // one expected plaintext together with the ciphertext that produced it
   typedef struct packed {
      block_type cipher;
      block_type plain;
   } decrypt_case_type;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   logic [31:0]                  req_cipher_high;
   logic [31:0]                  req_cipher_low;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic [31:0]                  rsp_plain_high;
   logic [31:0]                  rsp_plain_low;
   logic                         csr_valid;
   logic                         csr_ready;
   logic [CSR_INDEX_WIDTH-1:0]   csr_index;
   logic [31:0]                  csr_data;

   // key as the block should hold it right now
   key_type                      key_now;
   // plaintexts still owed by the block, oldest first
   decrypt_case_type             plain_expected [$];
   // percent of cycles in which each side idles
   int unsigned                  req_idle_pct = 0;
   int unsigned                  rsp_idle_pct = 0;
   // receiver holds off completely while set
   logic                         rsp_hold = 1'b0;
   int unsigned                  fail_count = 0;

   tea_block_decrypt #(
      .ROUNDS(ROUNDS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_cipher_high(req_cipher_high),
      .req_cipher_low(req_cipher_low),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_plain_high(rsp_plain_high),
      .rsp_plain_low(rsp_plain_low),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial clock = 1'b0;
   always begin
      #(CLOCK_PERIOD / 2) clock = 1'b1;
      #(CLOCK_PERIOD / 2) clock = 1'b0;
   end

   // tea decipher at the current key: the sum starts at delta times the round
   // count and walks back down by delta, second word first in every round
   function automatic block_type tea_decipher(input block_type cipher);
      word_type hi;
      word_type lo;
      word_type sum;
      hi = cipher.hi;
      lo = cipher.lo;
      sum = TEA_DELTA * word_type'(ROUNDS);
      for (int r = 0; r < ROUNDS; r++) begin
         lo -= ((hi << 4) + key_now.k2) ^ (hi + sum) ^ ((hi >> 5) + key_now.k3);
         hi -= ((lo << 4) + key_now.k0) ^ (lo + sum) ^ ((lo >> 5) + key_now.k1);
         sum -= TEA_DELTA;
      end
      return '{hi: hi, lo: lo};
   endfunction

   // mostly uniform words, with a share of extremes and near-extremes
   function automatic word_type random_word();
      case ($urandom_range(15))
         0: return '0;
         1: return ALL_ONES;
         2: return word_type'($urandom_range(255));
         3: return ~word_type'($urandom_range(255));
         default: return $urandom();
      endcase
   endfunction

   function automatic block_type random_block();
      return '{hi: random_word(), lo: random_word()};
   endfunction

   function automatic key_type random_key();
      return '{k0: random_word(), k1: random_word(), k2: random_word(), k3: random_word()};
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      fail_count++;
   endtask

   // offers one ciphertext item after a random gap and holds it until taken;
   // valid stays high afterwards so back-to-back items need no extra edge
   task automatic send_block(input block_type cipher);
      decrypt_case_type entry;
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cipher_high <= cipher.hi;
      req_cipher_low <= cipher.lo;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      entry.cipher = cipher;
      entry.plain = tea_decipher(cipher);
      plain_expected.push_back(entry);
   endtask

   // sender stops and waits until every owed plaintext has come back
   task automatic wait_plain_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (plain_expected.size() != 0);
   endtask

   // one register write, valid left high for a following write
   task automatic write_key_word(input logic [CSR_INDEX_WIDTH-1:0] index,
                                 input word_type value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         CSR_KEY_WORD_0: key_now.k0 = value;
         CSR_KEY_WORD_1: key_now.k1 = value;
         CSR_KEY_WORD_2: key_now.k2 = value;
         CSR_KEY_WORD_3: key_now.k3 = value;
         default: ;
      endcase
   endtask

   // only called while the block is empty
   task automatic load_key(input key_type key_value);
      write_key_word(CSR_KEY_WORD_0, key_value.k0);
      write_key_word(CSR_KEY_WORD_1, key_value.k1);
      write_key_word(CSR_KEY_WORD_2, key_value.k2);
      write_key_word(CSR_KEY_WORD_3, key_value.k3);
      csr_valid <= 1'b0;
   endtask

   // receiver: random stall at the chosen rate, or a solid hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (rsp_hold) begin
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   // every plaintext item taken is compared with the oldest one owed
   always @(posedge clock) begin : check_plain
      decrypt_case_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (plain_expected.size() == 0) begin
            report_mismatch($sformatf("plaintext %h_%h with none owed",
                                      rsp_plain_high, rsp_plain_low));
         end else begin
            want = plain_expected.pop_front();
            if (rsp_plain_high !== want.plain.hi)
               report_mismatch($sformatf("cipher %h_%h plain_high got %h want %h",
                                         want.cipher.hi, want.cipher.lo,
                                         rsp_plain_high, want.plain.hi));
            if (rsp_plain_low !== want.plain.lo)
               report_mismatch($sformatf("cipher %h_%h plain_low got %h want %h",
                                         want.cipher.hi, want.cipher.lo,
                                         rsp_plain_low, want.plain.lo));
         end
      end
   end

   // reset key: corner ciphertexts, then a set bit walking across the high word and a clear bit across the low word
   task automatic test_reset_key();
      for (int i = 0; i < 9; i++) send_block(block_type'(CORNER_BLOCKS[i]));
      for (int i = 0; i < 8; i++) begin
         send_block('{hi: word_type'(1) << (4 * i + 1), lo: ~(word_type'(1) << (4 * i + 2))});
      end
      wait_plain_drained();
   endtask

   // all-zero key, all-ones key and a mixed extreme key
   task automatic test_key_extremes();
      key_type extremes [3];
      extremes[0] = '{k0: '0, k1: '0, k2: '0, k3: '0};
      extremes[1] = '{k0: ALL_ONES, k1: ALL_ONES, k2: ALL_ONES, k3: ALL_ONES};
      extremes[2] = '{k0: '0, k1: ALL_ONES, k2: '0, k3: ALL_ONES};
      for (int k = 0; k < 3; k++) begin
         load_key(extremes[k]);
         send_block('{hi: '0, lo: '0});
         send_block('{hi: ALL_ONES, lo: ALL_ONES});
         for (int i = 0; i < 8; i++) send_block(random_block());
         wait_plain_drained();
      end
   endtask

   // random blocks in three key phases: one key word changed, then two fresh keys
   task automatic test_random_traffic(input int unsigned sender_idle,
                                      input int unsigned receiver_idle,
                                      input int unsigned block_count);
      key_type next_key;
      req_idle_pct = sender_idle;
      rsp_idle_pct <= receiver_idle;
      for (int phase = 0; phase < 3; phase++) begin
         if (phase == 0) begin
            next_key = key_now;
            case (CSR_INDEX_WIDTH'($urandom_range(3)))
               CSR_KEY_WORD_0: next_key.k0 = random_word();
               CSR_KEY_WORD_1: next_key.k1 = random_word();
               CSR_KEY_WORD_2: next_key.k2 = random_word();
               default: next_key.k3 = random_word();
            endcase
         end else begin
            next_key = random_key();
         end
         load_key(next_key);
         for (int i = 0; i < block_count / 3; i++) send_block(random_block());
         wait_plain_drained();
      end
   endtask

   // receiver holds off while the sender keeps offering, so the pipe and the
   // queue fill and the input stalls; afterwards everything must drain in order
   task automatic test_output_hold();
      req_idle_pct = 0;
      rsp_idle_pct <= 0;
      fork
         begin
            rsp_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold <= 1'b0;
         end
      join_none
      for (int i = 0; i < 100; i++) send_block(random_block());
      wait_plain_drained();
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_cipher_high <= '0;
      req_cipher_low <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_KEY_WORD_0;
      csr_data <= '0;
      key_now = '{k0: KEY_0_RESET, k1: KEY_1_RESET, k2: KEY_2_RESET, k3: KEY_3_RESET};
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_reset_key();
      test_key_extremes();
      // sender rarely idle, receiver mostly stalled
      test_random_traffic(8, 81, 420);
      // sender mostly idle, receiver rarely stalled
      test_random_traffic(81, 8, 420);
      // full rate on both sides
      test_random_traffic(0, 0, 420);
      test_output_hold();

      // let any stray result show up before the verdict
      for (int n = 0; n < DRAIN_LIMIT && plain_expected.size() != 0; n++) @(posedge clock);
      repeat (PIPE_LATENCY + 16) @(posedge clock);
      if (plain_expected.size() != 0)
         report_mismatch($sformatf("%0d plaintexts never arrived", plain_expected.size()));
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // hard stop if a handshake never completes
   initial begin
      #(CLOCK_PERIOD * TIMEOUT_CYCLES);
      $display("timeout with %0d plaintexts owed", plain_expected.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
